[rtl/ssf_pkg.sv]
// ============================================================================
// ssf_pkg
// Shared types and fixed constants of the state-space filter.
// ============================================================================
`timescale 1ns / 1ps

package ssf_pkg;

    localparam int STATE_WIDTH    = 48;
    localparam int STATE_FRAC     = 24;
    localparam int ORDER_WIDTH    = 4;
    localparam int MODE_WIDTH     = 2;
    localparam int PADDR_WIDTH    = 3;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic [MODE_WIDTH-1:0] MODE_FILTER = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_COEF   = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_STATE  = 2'd2;

    localparam logic [PADDR_WIDTH-1:0] REG_ACTIVE_ORDER = 3'd0;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic is_y;
    } ssf_tag_t;

    typedef struct packed {
        logic                   valid;
        logic                   is_y;
        logic                   sat;
        logic [STATE_WIDTH-1:0] value;
    } ssf_res_t;

endpackage

[rtl/ssf_mac.sv]
// ============================================================================
// ssf_mac
// Pipelined multiply-accumulate with round-half-up and saturation.
// ============================================================================
`timescale 1ns / 1ps

module ssf_mac #(
    parameter int MAX_ORDER    = 8,
    parameter int COEF_WIDTH   = 48,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ssf_pkg::ssf_tag_t                    tag,
    input  logic [COEF_WIDTH-1:0]                coef_word,
    input  logic [ssf_pkg::STATE_WIDTH-1:0]      state_word,
    input  logic [ssf_pkg::STATE_WIDTH-1:0]      ushift,
    output ssf_pkg::ssf_res_t                    res
);
    import ssf_pkg::*;

    localparam int CL      = (COEF_WIDTH + 1) / 2;
    localparam int CH      = COEF_WIDTH - CL;
    localparam int HW      = STATE_WIDTH / 2;
    localparam int PROD_W  = COEF_WIDTH + STATE_WIDTH;
    localparam int ACC_W   = PROD_W + $clog2(MAX_ORDER + 1) + 1;
    localparam int SHIFT_X = COEF_WIDTH - 8;
    localparam int SHIFT_Y = COEF_WIDTH - 8 + STATE_FRAC - SAMPLE_WIDTH / 2;
    localparam logic signed [ACC_W-1:0] HALF_X = ACC_W'(1) << (SHIFT_X - 1);
    localparam logic signed [ACC_W-1:0] HALF_Y = ACC_W'(1) << (SHIFT_Y - 1);

    logic [STATE_WIDTH-1:0]     operand;
    logic signed [CH-1:0]       c_hi;
    logic [CL-1:0]              c_lo;
    logic signed [HW-1:0]       o_hi;
    logic [HW-1:0]              o_lo;

    logic signed [CH+HW-1:0]    pp_hh_next, pp_hh_reg;
    logic signed [CH+HW:0]      pp_hl_next, pp_hl_reg;
    logic signed [CL+HW:0]      pp_lh_next, pp_lh_reg;
    logic [CL+HW-1:0]           pp_ll_next, pp_ll_reg;
    logic signed [PROD_W-1:0]   pa_next, pa_reg;
    logic signed [PROD_W-1:0]   pb_next, pb_reg;
    logic signed [ACC_W-1:0]    acc_next, acc_reg;
    logic signed [ACC_W-1:0]    rnd_next, rnd_reg;
    ssf_tag_t                   tag_a_reg, tag_b_reg, tag_c_reg;
    logic                       rnd_valid_next, rnd_valid_reg;
    logic                       rnd_is_y_next, rnd_is_y_reg;
    ssf_res_t                   res_next, res_reg;

    logic [ACC_W-SAMPLE_WIDTH:0]      hi_y;
    logic [ACC_W-STATE_WIDTH:0]       hi_x;
    logic                             fits_y, fits_x, neg;
    logic signed [SAMPLE_WIDTH-1:0]   y_lim;
    logic signed [STATE_WIDTH-1:0]    x_lim;

    // stage A: partial products
    always_comb
    begin
        operand    = tag.first ? ushift : state_word;
        c_hi       = coef_word[COEF_WIDTH-1:CL];
        c_lo       = coef_word[CL-1:0];
        o_hi       = operand[STATE_WIDTH-1:HW];
        o_lo       = operand[HW-1:0];
        pp_hh_next = c_hi * o_hi;
        pp_hl_next = c_hi * $signed({1'b0, o_lo});
        pp_lh_next = $signed({1'b0, c_lo}) * o_hi;
        pp_ll_next = c_lo * o_lo;
    end

    // stage B: combine partial products
    always_comb
    begin
        pa_next = $signed({pp_hh_reg, pp_ll_reg});
        pb_next = (PROD_W'(pp_hl_reg) <<< CL) + (PROD_W'(pp_lh_reg) <<< HW);
    end

    // stage C: accumulate, D: round, E: clip
    always_comb
    begin
        acc_next = acc_reg;
        if (tag_b_reg.valid)
        begin
            acc_next = (tag_b_reg.first ? '0 : acc_reg) + ACC_W'(pa_reg) + ACC_W'(pb_reg);
        end

        rnd_valid_next = tag_c_reg.valid && tag_c_reg.last;
        rnd_is_y_next  = tag_c_reg.is_y;
        if (tag_c_reg.is_y)
        begin
            rnd_next = (acc_reg + HALF_Y) >>> SHIFT_Y;
        end
        else
        begin
            rnd_next = (acc_reg + HALF_X) >>> SHIFT_X;
        end

        hi_y   = rnd_reg[ACC_W-1:SAMPLE_WIDTH-1];
        hi_x   = rnd_reg[ACC_W-1:STATE_WIDTH-1];
        fits_y = (&hi_y) || !(|hi_y);
        fits_x = (&hi_x) || !(|hi_x);
        neg    = rnd_reg[ACC_W-1];
        y_lim  = neg ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        x_lim  = neg ? {1'b1, {(STATE_WIDTH-1){1'b0}}} : {1'b0, {(STATE_WIDTH-1){1'b1}}};

        res_next.valid = rnd_valid_reg;
        res_next.is_y  = rnd_is_y_reg;
        if (rnd_is_y_reg)
        begin
            res_next.sat   = !fits_y;
            res_next.value = fits_y ? rnd_reg[STATE_WIDTH-1:0] : STATE_WIDTH'(y_lim);
        end
        else
        begin
            res_next.sat   = !fits_x;
            res_next.value = fits_x ? rnd_reg[STATE_WIDTH-1:0] : x_lim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg     <= '0;
            tag_b_reg     <= '0;
            tag_c_reg     <= '0;
            rnd_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            tag_a_reg     <= tag;
            tag_b_reg     <= tag_a_reg;
            tag_c_reg     <= tag_b_reg;
            rnd_valid_reg <= rnd_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_hh_reg    <= pp_hh_next;
        pp_hl_reg    <= pp_hl_next;
        pp_lh_reg    <= pp_lh_next;
        pp_ll_reg    <= pp_ll_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        acc_reg      <= acc_next;
        rnd_reg      <= rnd_next;
        rnd_is_y_reg <= rnd_is_y_next;
    end

    assign res = res_reg;

endmodule

[rtl/ssf_ctrl.sv]
// ============================================================================
// ssf_ctrl
// Sequencer, coefficient and state memories, and result register.
// ============================================================================
`timescale 1ns / 1ps

module ssf_ctrl #(
    parameter int MAX_ORDER    = 8,
    parameter int COEF_WIDTH   = 48,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic [ssf_pkg::ORDER_WIDTH-1:0]                 active_order,
    input  logic                                            item_valid,
    output logic                                            item_ready,
    input  logic [ssf_pkg::MODE_WIDTH-1:0]                  mode,
    input  logic signed [SAMPLE_WIDTH-1:0]                  sample_in,
    input  logic [$clog2(MAX_ORDER*MAX_ORDER+2*MAX_ORDER+1)-1:0] load_index,
    input  logic signed [ssf_pkg::STATE_WIDTH-1:0]          load_word,
    output ssf_pkg::ssf_tag_t                               tag,
    output logic [COEF_WIDTH-1:0]                           coef_word,
    output logic [ssf_pkg::STATE_WIDTH-1:0]                 state_word,
    output logic [ssf_pkg::STATE_WIDTH-1:0]                 ushift,
    input  ssf_pkg::ssf_res_t                               res,
    output logic                                            result_valid,
    input  logic                                            result_ready,
    output logic signed [SAMPLE_WIDTH-1:0]                  filtered_out,
    output logic                                            saturated
);
    import ssf_pkg::*;

    localparam int COEF_DEPTH = MAX_ORDER * MAX_ORDER + 2 * MAX_ORDER + 1;
    localparam int B_BASE     = MAX_ORDER * MAX_ORDER;
    localparam int C_BASE     = MAX_ORDER * MAX_ORDER + MAX_ORDER;
    localparam int D_INDEX    = MAX_ORDER * MAX_ORDER + 2 * MAX_ORDER;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int SA_W       = $clog2(2 * MAX_ORDER);
    localparam int ORD_W      = $clog2(MAX_ORDER + 1);
    localparam int U_SHIFT    = STATE_FRAC - SAMPLE_WIDTH / 2;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_COPY  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [COEF_WIDTH-1:0]   coef_mem [COEF_DEPTH];
    logic [STATE_WIDTH-1:0]  st_mem [2*MAX_ORDER];

    logic [2:0]              state_reg, state_next;
    logic [CA_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [ORD_W-1:0]        n_reg, n_next;
    logic [ORD_W-1:0]        row_reg, row_next;
    logic [ORD_W-1:0]        term_reg, term_next;
    logic [CA_W-1:0]         abase_reg, abase_next;
    logic [ORD_W-1:0]        wr_row_reg, wr_row_next;
    logic [ORD_W-1:0]        copy_cnt_reg, copy_cnt_next;
    logic                    cp_valid_reg, cp_valid_next;
    logic [SA_W-1:0]         cp_addr_reg, cp_addr_next;
    logic [STATE_WIDTH-1:0]  ushift_reg, ushift_next;
    logic [SAMPLE_WIDTH-1:0] y_reg, y_next;
    logic                    sat_reg, sat_next;
    ssf_tag_t                tag_reg, tag_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] out_y_reg, out_y_next;
    logic                    out_sat_reg, out_sat_next;
    logic [COEF_WIDTH-1:0]   coef_rd_reg;
    logic [STATE_WIDTH-1:0]  st_rd_reg;

    logic                    accept;
    logic                    out_load;
    logic [ORD_W-1:0]        n_clamp;
    logic [ORD_W-1:0]        term_m1, row_m1;
    logic [CA_W-1:0]         coef_raddr, coef_waddr;
    logic                    coef_we;
    logic [COEF_WIDTH-1:0]   coef_wdata;
    logic [SA_W-1:0]         st_raddr, st_waddr;
    logic                    st_we;
    logic [STATE_WIDTH-1:0]  st_wdata;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        if (active_order == '0)
        begin
            n_clamp = ORD_W'(1);
        end
        else if (active_order > MAX_ORDER)
        begin
            n_clamp = ORD_W'(MAX_ORDER);
        end
        else
        begin
            n_clamp = ORD_W'(active_order);
        end
    end

    // read addresses
    always_comb
    begin
        term_m1 = term_reg - ORD_W'(1);
        row_m1  = row_reg - ORD_W'(1);
        if (term_reg == '0)
        begin
            coef_raddr = (row_reg == '0) ? CA_W'(D_INDEX) : CA_W'(B_BASE) + CA_W'(row_m1);
        end
        else
        begin
            coef_raddr = (row_reg == '0) ? CA_W'(C_BASE) + CA_W'(term_m1)
                                         : abase_reg + CA_W'(term_m1);
        end
        if (state_reg == ST_COPY)
        begin
            st_raddr = SA_W'(MAX_ORDER) + SA_W'(copy_cnt_reg);
        end
        else
        begin
            st_raddr = SA_W'(term_m1);
        end
    end

    // write ports
    always_comb
    begin
        coef_we    = 1'b0;
        coef_waddr = clr_cnt_reg;
        coef_wdata = '0;
        st_we      = 1'b0;
        st_waddr   = clr_cnt_reg[SA_W-1:0];
        st_wdata   = '0;
        if (state_reg == ST_CLEAR)
        begin
            coef_we = 1'b1;
            st_we   = (clr_cnt_reg < MAX_ORDER);
        end
        else if (accept && mode == MODE_COEF)
        begin
            coef_we    = (load_index < COEF_DEPTH);
            coef_waddr = CA_W'(load_index);
            coef_wdata = COEF_WIDTH'($unsigned(load_word));
        end
        else if (accept && mode == MODE_STATE)
        begin
            st_we    = (load_index < MAX_ORDER);
            st_waddr = load_index[SA_W-1:0];
            st_wdata = load_word;
        end
        else if (res.valid && !res.is_y)
        begin
            st_we    = 1'b1;
            st_waddr = SA_W'(MAX_ORDER) + SA_W'(wr_row_reg);
            st_wdata = res.value;
        end
        else if (cp_valid_reg)
        begin
            st_we    = 1'b1;
            st_waddr = cp_addr_reg;
            st_wdata = st_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_rd_reg <= coef_mem[coef_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_rd_reg <= st_mem[st_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        n_next         = n_reg;
        row_next       = row_reg;
        term_next      = term_reg;
        abase_next     = abase_reg;
        wr_row_next    = wr_row_reg;
        copy_cnt_next  = copy_cnt_reg;
        ushift_next    = ushift_reg;
        y_next         = y_reg;
        sat_next       = sat_reg;
        tag_next       = '0;
        cp_valid_next  = (state_reg == ST_COPY);
        cp_addr_next   = SA_W'(copy_cnt_reg);
        out_load       = 1'b0;

        if (res.valid)
        begin
            sat_next = sat_reg | res.sat;
            if (res.is_y)
            begin
                y_next = res.value[SAMPLE_WIDTH-1:0];
            end
            else
            begin
                wr_row_next = wr_row_reg + ORD_W'(1);
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + CA_W'(1);
                if (clr_cnt_reg == CA_W'(COEF_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && mode == MODE_FILTER)
                begin
                    n_next      = n_clamp;
                    row_next    = '0;
                    term_next   = '0;
                    abase_next  = '0;
                    wr_row_next = '0;
                    sat_next    = 1'b0;
                    ushift_next = STATE_WIDTH'(sample_in) << U_SHIFT;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                tag_next.valid = 1'b1;
                tag_next.first = (term_reg == '0);
                tag_next.last  = (term_reg == n_reg);
                tag_next.is_y  = (row_reg == '0);
                if (term_reg == n_reg)
                begin
                    term_next = '0;
                    row_next  = row_reg + ORD_W'(1);
                    if (row_reg != '0)
                    begin
                        abase_next = abase_reg + CA_W'(MAX_ORDER);
                    end
                    if (row_reg == n_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    term_next = term_reg + ORD_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (res.valid && !res.is_y && wr_row_reg == n_reg - ORD_W'(1))
                begin
                    copy_cnt_next = '0;
                    state_next    = ST_COPY;
                end
            end
            ST_COPY:
            begin
                copy_cnt_next = copy_cnt_reg + ORD_W'(1);
                if (copy_cnt_reg == n_reg - ORD_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_y_next     = out_y_reg;
        out_sat_next   = out_sat_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_y_next     = y_reg;
            out_sat_next   = sat_reg;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            n_reg         <= ORD_W'(1);
            row_reg       <= '0;
            term_reg      <= '0;
            abase_reg     <= '0;
            wr_row_reg    <= '0;
            copy_cnt_reg  <= '0;
            cp_valid_reg  <= 1'b0;
            tag_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            n_reg         <= n_next;
            row_reg       <= row_next;
            term_reg      <= term_next;
            abase_reg     <= abase_next;
            wr_row_reg    <= wr_row_next;
            copy_cnt_reg  <= copy_cnt_next;
            cp_valid_reg  <= cp_valid_next;
            tag_reg       <= tag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_addr_reg <= cp_addr_next;
        ushift_reg  <= ushift_next;
        y_reg       <= y_next;
        sat_reg     <= sat_next;
        out_y_reg   <= out_y_next;
        out_sat_reg <= out_sat_next;
    end

    assign tag          = tag_reg;
    assign coef_word    = coef_rd_reg;
    assign state_word   = st_rd_reg;
    assign ushift       = ushift_reg;
    assign result_valid = out_valid_reg;
    assign filtered_out = out_y_reg;
    assign saturated    = out_sat_reg;

endmodule

[rtl/state_space_filter_siso_top.sv]
// ============================================================================
// state_space_filter_siso_top
// Filter word: the output row and the n state rows of MAC terms run on one
// shared pipelined multiplier, then the new state is copied back; the next
// word is taken once the result has been loaded. Load words need no filter pass.
// After reset a clearing pass zeroes the coefficient memory and the current
// half of the state memory; item_ready stays low.
// ============================================================================
`timescale 1ns / 1ps

module state_space_filter_siso_top #(
    parameter int MAX_ORDER    = 8,
    parameter int COEF_WIDTH   = 48,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            psel,
    input  logic                                            penable,
    input  logic                                            pwrite,
    input  logic [ssf_pkg::PADDR_WIDTH-1:0]                 paddr,
    input  logic [ssf_pkg::APB_DATA_WIDTH-1:0]              pwdata,
    output logic [ssf_pkg::APB_DATA_WIDTH-1:0]              prdata,
    output logic                                            pready,
    input  logic                                            item_valid,
    output logic                                            item_ready,
    input  logic [ssf_pkg::MODE_WIDTH-1:0]                  mode,
    input  logic signed [SAMPLE_WIDTH-1:0]                  sample_in,
    input  logic [$clog2(MAX_ORDER*MAX_ORDER+2*MAX_ORDER+1)-1:0] load_index,
    input  logic signed [ssf_pkg::STATE_WIDTH-1:0]          load_word,
    output logic                                            result_valid,
    input  logic                                            result_ready,
    output logic signed [SAMPLE_WIDTH-1:0]                  filtered_out,
    output logic                                            saturated
);
    import ssf_pkg::*;

    logic [ORDER_WIDTH-1:0]  active_order_reg;
    ssf_tag_t                tag;
    ssf_res_t                res;
    logic [COEF_WIDTH-1:0]   coef_word;
    logic [STATE_WIDTH-1:0]  state_word;
    logic [STATE_WIDTH-1:0]  ushift;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ACTIVE_ORDER) ? APB_DATA_WIDTH'(active_order_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_order_reg <= ORDER_WIDTH'(1);
        end
        else if (psel && penable && pwrite && pready && paddr == REG_ACTIVE_ORDER)
        begin
            active_order_reg <= pwdata[ORDER_WIDTH-1:0];
        end
    end

    ssf_ctrl #(
        .MAX_ORDER    (MAX_ORDER),
        .COEF_WIDTH   (COEF_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .active_order (active_order_reg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .sample_in    (sample_in),
        .load_index   (load_index),
        .load_word    (load_word),
        .tag          (tag),
        .coef_word    (coef_word),
        .state_word   (state_word),
        .ushift       (ushift),
        .res          (res),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .filtered_out (filtered_out),
        .saturated    (saturated)
    );

    ssf_mac #(
        .MAX_ORDER    (MAX_ORDER),
        .COEF_WIDTH   (COEF_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag        (tag),
        .coef_word  (coef_word),
        .state_word (state_word),
        .ushift     (ushift),
        .res        (res)
    );

endmodule

[dv/tb.sv]
// ============================================================================
// tb
// Self-checking bench for the state-space filter: loads coefficient and
// state words, sets the order over the register port, filters samples and
// checks each filtered word against an in-bench fixed-point prediction.
// Directed corner cases come first, then random phases of load-and-filter
// sequences mixed with noise, with random stalls on both channels.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import ssf_pkg::*;

    localparam int MAX_ORDER    = 8;
    localparam int COEF_DEPTH   = 81;
    localparam int B_BASE       = 64;
    localparam int C_BASE       = 72;
    localparam int D_INDEX      = 80;
    localparam int TARGET_WORDS = 1850;
    localparam int DRAIN_CYCLES = 150;
    localparam longint CYCLE_LIMIT = 4000000;

    localparam logic [MODE_WIDTH-1:0]  MODE_IGNORED = 2'd3;
    localparam logic [PADDR_WIDTH-1:0] REG_UNMAPPED = 3'd4;

    localparam logic signed [47:0] COEF_ONE  = 48'sh0100_0000_0000;
    localparam logic signed [47:0] WORD_MAX  = 48'sh7fff_ffff_ffff;
    localparam logic signed [47:0] WORD_MIN  = 48'sh8000_0000_0000;
    localparam logic signed [31:0] SAMPLE_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [31:0] y;
        logic        sat;
    } y_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_WIDTH-1:0]    paddr = '0;
    logic [APB_DATA_WIDTH-1:0] pwdata = '0;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;
    logic                      item_valid = 1'b0;
    logic                      item_ready;
    logic [MODE_WIDTH-1:0]     mode = MODE_FILTER;
    logic signed [31:0]        sample_in = '0;
    logic [6:0]                load_index = '0;
    logic signed [47:0]        load_word = '0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    logic signed [31:0]        filtered_out;
    logic                      saturated;

    logic signed [47:0] coef_model [COEF_DEPTH];
    logic signed [47:0] state_model [MAX_ORDER];
    logic [3:0]         order_model;

    y_word_t expected_y_q [$];
    y_word_t y_head;

    int     error_count = 0;
    int     words_sent = 0;
    int     samples_checked = 0;
    int     phase_count = 0;
    int     ready_hold = 0;
    bit     bursty = 1'b0;
    longint cycle_count = 0;

    state_space_filter_siso_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .sample_in    (sample_in),
        .load_index   (load_index),
        .load_word    (load_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .filtered_out (filtered_out),
        .saturated    (saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed-point prediction
    // ------------------------------------------------------------------------
    function automatic wide_t wide_mul(logic signed [47:0] a, logic signed [47:0] b);
        wide_t x;
        wide_t z;
        x = a;
        z = b;
        return x * z;
    endfunction

    function automatic logic [47:0] round_clip(wide_t v, int s, int w, inout bit sat);
        wide_t r;
        wide_t hi;
        wide_t lo;
        r  = (v + (wide_t'(1) <<< (s - 1))) >>> s;
        hi = (wide_t'(1) <<< (w - 1)) - 1;
        lo = -(wide_t'(1) <<< (w - 1));
        if (r > hi)
        begin
            sat = 1'b1;
            r = hi;
        end
        else if (r < lo)
        begin
            sat = 1'b1;
            r = lo;
        end
        return r[47:0];
    endfunction

    function automatic int eff_order(logic [3:0] ord);
        if (ord < 1)
            return 1;
        if (ord > MAX_ORDER)
            return MAX_ORDER;
        return int'(ord);
    endfunction

    function automatic y_word_t filter_step(logic signed [31:0] u);
        int                 n;
        wide_t              acc;
        logic signed [47:0] next_x [MAX_ORDER];
        logic [47:0]        y48;
        bit                 sat;
        y_word_t            res;
        sat = 1'b0;
        n = eff_order(order_model);
        acc = wide_mul(coef_model[D_INDEX], u) <<< 8;
        for (int c = 0; c < n; c++)
            acc += wide_mul(coef_model[C_BASE + c], state_model[c]);
        y48 = round_clip(acc, 48, 32, sat);
        for (int r = 0; r < n; r++)
        begin
            acc = wide_mul(coef_model[B_BASE + r], u) <<< 8;
            for (int c = 0; c < n; c++)
                acc += wide_mul(coef_model[r * MAX_ORDER + c], state_model[c]);
            next_x[r] = round_clip(acc, 40, 48, sat);
        end
        for (int r = 0; r < n; r++)
            state_model[r] = next_x[r];
        res.y = y48[31:0];
        res.sat = sat;
        return res;
    endfunction

    function automatic void apply_word(logic [1:0] m, logic signed [31:0] u,
                                       logic [6:0] idx, logic [47:0] w);
        case (m)
            MODE_FILTER:
            begin
                expected_y_q.push_back(filter_step(u));
                words_sent++;
            end
            MODE_COEF:
            begin
                if (idx < COEF_DEPTH)
                begin
                    coef_model[idx] = w;
                    words_sent++;
                end
            end
            MODE_STATE:
            begin
                if (idx < MAX_ORDER)
                begin
                    state_model[idx[2:0]] = w;
                    words_sent++;
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    function automatic logic [47:0] rand_word48();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[47:0];
    endfunction

    function automatic logic [47:0] rand_signed(int bits);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        raw = raw >> (64 - bits);
        if ($urandom_range(0, 1))
            raw = -raw;
        return raw[47:0];
    endfunction

    function automatic logic [47:0] pick_coef(int scale, int bits);
        case (scale)
            0: return rand_word48();
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return WORD_MAX;
                    1: return WORD_MIN;
                    2: return '0;
                    3: return COEF_ONE;
                    default: return -COEF_ONE;
                endcase
            end
            default: return rand_signed(bits);
        endcase
    endfunction

    function automatic logic [31:0] pick_sample();
        logic [47:0] v;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 2))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    default: return '0;
                endcase
            end
            default:
            begin
                v = rand_signed(24);
                return v[31:0];
            end
        endcase
    endfunction

    function automatic logic [47:0] pick_state();
        if ($urandom_range(0, 3) == 0)
            return rand_word48();
        return rand_signed(30);
    endfunction

    // ------------------------------------------------------------------------
    // Input channel and register port
    // ------------------------------------------------------------------------
    task automatic send_word(logic [1:0] m, logic signed [31:0] u,
                             logic [6:0] idx, logic [47:0] w);
        int gap;
        item_valid <= 1'b1;
        mode       <= m;
        sample_in  <= u;
        load_index <= idx;
        load_word  <= w;
        do @(posedge clk); while (!item_ready);
        apply_word(m, u, idx, w);
        gap = bursty ? gap_len() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_coef(int idx, logic [47:0] w);
        send_word(MODE_COEF, $urandom, idx[6:0], w);
    endtask

    task automatic load_state(int idx, logic [47:0] w);
        send_word(MODE_STATE, $urandom, idx[6:0], w);
    endtask

    task automatic filter_sample(logic signed [31:0] u);
        send_word(MODE_FILTER, u, 7'($urandom_range(0, 127)), rand_word48());
    endtask

    // drop valid, wait for every filtered word, then let loads finish
    task automatic settle();
        item_valid <= 1'b0;
        while (expected_y_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [PADDR_WIDTH-1:0] addr, logic [3:0] value);
        logic [27:0] upper;
        logic [31:0] data;
        upper = 28'($urandom);
        data = {upper, value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == REG_ACTIVE_ORDER)
            order_model = data[3:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_order_reg();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_ACTIVE_ORDER;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {28'd0, order_model})
        begin
            $error("active_order mismatch: expected %h, got %h", {28'd0, order_model}, got);
            error_count++;
        end
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold = ready_hold - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            if (bursty && $urandom_range(0, 3) == 0)
                ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                         : $urandom_range(1, 3);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_y_q.size() == 0)
            begin
                $error("filtered word with none expected: filtered_out %h", filtered_out);
                error_count++;
            end
            else
            begin
                y_head = expected_y_q.pop_front();
                samples_checked++;
                if (filtered_out !== y_head.y)
                begin
                    $error("filtered_out mismatch: expected %h, got %h", y_head.y, filtered_out);
                    error_count++;
                end
                if (saturated !== y_head.sat)
                begin
                    $error("saturated mismatch: expected %b, got %b", y_head.sat, saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending",
                     cycle_count, expected_y_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state();
        check_order_reg();
        filter_sample(SAMPLE_MAX);
        filter_sample(SAMPLE_MIN);
        filter_sample('0);
    endtask

    task automatic test_extremes();
        load_coef(D_INDEX, COEF_ONE);
        filter_sample(SAMPLE_MAX);
        filter_sample(SAMPLE_MIN);
        load_coef(D_INDEX, WORD_MAX);
        filter_sample(SAMPLE_MAX);
        filter_sample(SAMPLE_MIN);
        load_coef(D_INDEX, WORD_MIN);
        filter_sample(SAMPLE_MIN);
        load_coef(C_BASE, COEF_ONE);
        load_state(0, WORD_MAX);
        filter_sample('0);
        load_coef(0, WORD_MAX);
        load_coef(B_BASE, WORD_MIN);
        load_state(0, WORD_MIN);
        filter_sample(SAMPLE_MAX);
        filter_sample(SAMPLE_MIN);
    endtask

    task automatic test_ignored_words();
        load_coef(COEF_DEPTH, WORD_MAX);
        load_coef(127, WORD_MIN);
        load_state(MAX_ORDER, WORD_MAX);
        load_state(127, WORD_MIN);
        send_word(MODE_IGNORED, SAMPLE_MAX, 7'h7f, WORD_MAX);
        send_word(MODE_IGNORED, SAMPLE_MIN, 7'h00, '0);
        filter_sample(pick_sample());
    endtask

    task automatic test_order_register();
        settle();
        write_reg(REG_ACTIVE_ORDER, 4'd0);
        check_order_reg();
        load_coef(C_BASE + 3, COEF_ONE);
        load_state(3, 48'sh0000_0100_0000);
        filter_sample(pick_sample());
        settle();
        write_reg(REG_UNMAPPED, 4'd5);
        check_order_reg();
        write_reg(REG_ACTIVE_ORDER, 4'd4);
        check_order_reg();
        filter_sample(pick_sample());
        settle();
        write_reg(REG_ACTIVE_ORDER, 4'd15);
        check_order_reg();
        filter_sample(pick_sample());
    endtask

    task automatic well_formed_run(int n);
        int scale;
        scale = $urandom_range(0, 5);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                load_coef(r * MAX_ORDER + c, pick_coef(scale, 37));
        for (int r = 0; r < n; r++)
            load_coef(B_BASE + r, pick_coef(scale, 40));
        for (int c = 0; c < n; c++)
            load_coef(C_BASE + c, pick_coef(scale, 40));
        load_coef(D_INDEX, pick_coef(scale, 40));
        if ($urandom_range(0, 1))
            for (int r = 0; r < n; r++)
                load_state(r, pick_state());
        repeat ($urandom_range(3, 12)) filter_sample(pick_sample());
    endtask

    task automatic noise_run();
        repeat ($urandom_range(5, 20))
            send_word(2'($urandom_range(0, 3)), $urandom, 7'($urandom_range(0, 127)),
                      rand_word48());
    endtask

    task automatic broken_run();
        repeat ($urandom_range(1, 10))
            load_coef($urandom_range(0, COEF_DEPTH - 1), pick_coef($urandom_range(0, 5), 38));
        repeat ($urandom_range(1, 4)) filter_sample(pick_sample());
    endtask

    task automatic test_random_phases();
        int pick;
        int kind;
        logic [3:0] ord;
        while (words_sent < TARGET_WORDS)
        begin
            settle();
            pick = $urandom_range(0, 11);
            case (pick)
                0: ord = 4'd0;
                1: ord = 4'd15;
                2: ord = 4'($urandom_range(9, 14));
                3, 4: ord = 4'd8;
                default: ord = 4'($urandom_range(1, 4));
            endcase
            write_reg(REG_ACTIVE_ORDER, ord);
            check_order_reg();
            bursty = ($urandom_range(0, 3) != 0);
            phase_count++;
            repeat ($urandom_range(2, 5))
            begin
                if (words_sent >= TARGET_WORDS)
                    break;
                kind = $urandom_range(0, 9);
                if (kind < 7)
                    well_formed_run(eff_order(order_model));
                else if (kind < 9)
                    noise_run();
                else
                    broken_run();
            end
        end
    endtask

    initial
    begin
        order_model = 4'd1;
        for (int i = 0; i < COEF_DEPTH; i++)
            coef_model[i] = '0;
        for (int i = 0; i < MAX_ORDER; i++)
            state_model[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        bursty = 1'b1;
        test_extremes();
        test_ignored_words();
        test_order_register();
        test_random_phases();

        settle();
        $display("Checked %0d filtered samples out of %0d words over %0d random phases.",
                 samples_checked, words_sent, phase_count);
        $display("Orders 0, 1 to 8, 9 to 15 and bad load indexes and mode three were driven.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
